/* hw/rtl/sgm_pkg.sv */
// shared types, register indexes and gradient helpers for the sobel zero-gradient mask
`default_nettype none

package sgm_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FIRST_ROW    = 2'd2;
    localparam logic [1:0] CFG_END_ROW      = 2'd3;

    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [11:0] RESET_IMAGE_WIDTH  = 12'd1024;
    localparam logic [12:0] RESET_IMAGE_HEIGHT = 13'd768;
    localparam logic [12:0] RESET_FIRST_ROW    = 13'd0;
    localparam logic [12:0] RESET_END_ROW      = 13'd4096;

    localparam logic [7:0] LEVEL_FLAT = 8'hFF;
    localparam logic [7:0] LEVEL_EDGE = 8'h00;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [10:0] col;
        logic [11:0] row;
        logic        write_enable;
        logic [7:0]  level;
        logic        last;
    } result_t;

    // one line store entry: gray value and alpha-zero flag
    typedef struct packed {
        logic       alpha_zero;
        logic [7:0] gray;
    } line_entry_t;

    // one window column, top in the low bits
    typedef struct packed {
        line_entry_t bot;
        line_entry_t mid;
        line_entry_t top;
    } column_t;

    function automatic line_entry_t make_entry(input pixel_t px);
        logic [12:0] gsum;
        line_entry_t e;
        gsum = 13'(px.red) * 13'd11 + 13'(px.green) * 13'd16 + 13'(px.blue) * 13'd5;
        e.gray       = gsum[12:5];
        e.alpha_zero = (px.alpha == 8'd0);
        return e;
    endfunction

    // weighted 1-2-1 sum of three gray values
    function automatic logic [9:0] tap_sum(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
        return 10'(a) + {1'b0, b, 1'b0} + 10'(c);
    endfunction

    // both gradients zero
    function automatic logic is_flat(input column_t cl, input column_t cc, input column_t cr);
        logic gx_zero;
        logic gy_zero;
        gx_zero = tap_sum(cr.top.gray, cr.mid.gray, cr.bot.gray)
               == tap_sum(cl.top.gray, cl.mid.gray, cl.bot.gray);
        gy_zero = tap_sum(cl.bot.gray, cc.bot.gray, cr.bot.gray)
               == tap_sum(cl.top.gray, cc.top.gray, cr.top.gray);
        return gx_zero && gy_zero;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sgm_line_buf.sv */
// two line stores (rows r-2 and r-1) with registered read and write-to-read bypass
`default_nettype none

module sgm_line_buf #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = 11
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rd_en,
    input  wire logic [AW-1:0]       rd_addr,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire sgm_pkg::line_entry_t wr_older,
    input  wire sgm_pkg::line_entry_t wr_prior,
    output sgm_pkg::line_entry_t     older_q,
    output sgm_pkg::line_entry_t     prior_q
);

    sgm_pkg::line_entry_t older_mem [DEPTH];
    sgm_pkg::line_entry_t prior_mem [DEPTH];

    sgm_pkg::line_entry_t older_rd_reg;
    sgm_pkg::line_entry_t prior_rd_reg;
    sgm_pkg::line_entry_t older_byp_reg;
    sgm_pkg::line_entry_t prior_byp_reg;
    logic                 byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            prior_mem[wr_addr] <= wr_prior;
        end
        if (rd_en)
        begin
            older_rd_reg  <= older_mem[rd_addr];
            prior_rd_reg  <= prior_mem[rd_addr];
            older_byp_reg <= wr_older;
            prior_byp_reg <= wr_prior;
        end
    end

    // a read landing on the entry being written this edge takes the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign older_q = byp_reg ? older_byp_reg : older_rd_reg;
    assign prior_q = byp_reg ? prior_byp_reg : prior_rd_reg;

endmodule

`default_nettype wire

/* hw/rtl/sobel_zero_gradient_mask.sv */
// top level of the streaming 3x3 sobel zero-gradient mask
`default_nettype none

// Takes one RGBA pixel per clock in raster order and returns, for each centre
// pixel, its column and row, a write enable (centre alpha nonzero and row in
// the configured window) and a level of 255 where both sobel gradients are zero,
// 0 otherwise. Borders are replicated. Results trail the input by one row and
// one column: the last column of a row is flushed by the pixel that ends the
// row, and the last row of a frame is flushed while the next frame's first row
// streams in. A pixel passes gray conversion and line store read, then window and
// gradient test, before its result reaches the output register. Sustained rate
// is one pixel per clock while results are not stalled; a pixel that ends a row
// and has a centre behind it causes two results, and since the single output
// register passes one result per cycle, such a pixel holds the input until its
// second result is registered. The user must write configuration only while the
// block is idle; the block does not enforce it. The line stores are not cleared
// after reset; entries read before being written give unspecified results,
// which only arise if the width grows beyond the columns earlier rows wrote.

module sobel_zero_gradient_mask #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // pixel channel
    input  wire logic                              pixel_valid,
    output logic                                   pixel_stall,
    input  wire sgm_pkg::pixel_t                   pixel,
    // result channel
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output sgm_pkg::result_t                       result,
    // configuration writes
    input  wire logic                              cfg_write,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [sgm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned CW   = $clog2(MAX_WIDTH);
    localparam int unsigned RW   = $clog2(MAX_HEIGHT);
    localparam int unsigned WCMP = (CW + 1 > 12) ? CW + 1 : 12;
    localparam int unsigned HCMP = (RW + 1 > 13) ? RW + 1 : 13;
    localparam int unsigned COLX = (CW > 11) ? CW : 11;
    localparam int unsigned ROWX = (RW > 12) ? RW : 12;

    // configuration registers
    logic [11:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [12:0] first_row_reg;
    logic [12:0] end_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= sgm_pkg::RESET_IMAGE_WIDTH;
            image_height_reg <= sgm_pkg::RESET_IMAGE_HEIGHT;
            first_row_reg    <= sgm_pkg::RESET_FIRST_ROW;
            end_row_reg      <= sgm_pkg::RESET_END_ROW;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sgm_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[11:0];
                sgm_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                sgm_pkg::CFG_FIRST_ROW:    first_row_reg    <= cfg_data;
                sgm_pkg::CFG_END_ROW:      end_row_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes, clamped to 1..max
    logic [WCMP-1:0] width_x;
    logic [HCMP-1:0] height_x;
    logic [CW:0]     w_eff;
    logic [RW:0]     h_eff;
    logic [CW:0]     w_last;
    logic [RW:0]     h_last;

    always_comb
    begin
        width_x  = WCMP'(image_width_reg);
        height_x = HCMP'(image_height_reg);
        if (width_x == '0)
            width_x = WCMP'(1);
        else if (width_x > WCMP'(MAX_WIDTH))
            width_x = WCMP'(MAX_WIDTH);
        if (height_x == '0)
            height_x = HCMP'(1);
        else if (height_x > HCMP'(MAX_HEIGHT))
            height_x = HCMP'(MAX_HEIGHT);
        w_eff  = width_x[CW:0];
        h_eff  = height_x[RW:0];
        w_last = w_eff - (CW+1)'(1);
        h_last = h_eff - (RW+1)'(1);
    end

    // ---------------- stage 0: position, gray, line store read ----------------
    logic [CW-1:0] col_count_reg;
    logic [RW-1:0] row_count_reg;
    logic [CW-1:0] c0;
    logic          line_end0;
    logic          frame_end0;
    logic          accept;
    logic          retire;

    always_comb
    begin
        c0 = col_count_reg;
        if ({1'b0, col_count_reg} >= w_eff)
            c0 = w_last[CW-1:0];
        line_end0  = ({1'b0, c0} >= w_last);
        frame_end0 = line_end0 && ({1'b0, row_count_reg} >= h_last);
    end

    assign accept = pixel_valid && !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            if (line_end0)
            begin
                col_count_reg <= '0;
                if (frame_end0)
                    row_count_reg <= '0;
                else
                    row_count_reg <= row_count_reg + RW'(1);
            end
            else
            begin
                col_count_reg <= c0 + CW'(1);
            end
        end
    end

    // ---------------- stage 1: window, gradients, result sequencing ----------------
    logic                 s1_valid_reg;
    logic                 s1_sub_reg;      // first of two results already sent
    sgm_pkg::line_entry_t s1_entry_reg;
    logic [CW-1:0]        s1_col_reg;
    logic [RW-1:0]        s1_row_reg;
    logic                 s1_line_end_reg;
    logic                 s1_frame_end_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_entry_reg     <= sgm_pkg::make_entry(pixel);
            s1_col_reg       <= c0;
            s1_row_reg       <= row_count_reg;
            s1_line_end_reg  <= line_end0;
            s1_frame_end_reg <= frame_end0;
        end
    end

    sgm_pkg::line_entry_t older_q;
    sgm_pkg::line_entry_t prior_q;

    sgm_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (c0),
        .wr_en    (retire),
        .wr_addr  (s1_col_reg),
        .wr_older (prior_q),
        .wr_prior (s1_entry_reg),
        .older_q  (older_q),
        .prior_q  (prior_q)
    );

    // window history, flush state of the previous frame's last row
    sgm_pkg::column_t win0_reg;
    sgm_pkg::column_t win1_reg;
    sgm_pkg::column_t win2_reg;
    logic             flush_pending_reg;
    logic [RW-1:0]    flush_row_reg;

    logic             first_row_of_frame;
    logic             active;
    logic [RW-1:0]    centre_row;
    sgm_pkg::column_t new_col;
    sgm_pkg::column_t win0_next;
    sgm_pkg::column_t win1_next;
    sgm_pkg::column_t left_b;
    logic             has_a;
    logic             has_b;
    logic             in_range;
    logic [HCMP-1:0]  row_x;

    always_comb
    begin
        first_row_of_frame = (s1_row_reg == '0);
        new_col.mid = prior_q;
        if (first_row_of_frame)
        begin
            // emitting the previous frame's last row, bottom clamped
            active      = flush_pending_reg;
            centre_row  = flush_row_reg;
            new_col.top = (flush_row_reg == '0) ? prior_q : older_q;
            new_col.bot = prior_q;
        end
        else
        begin
            active      = 1'b1;
            centre_row  = s1_row_reg - RW'(1);
            new_col.top = (s1_row_reg == RW'(1)) ? prior_q : older_q;
            new_col.bot = s1_entry_reg;
        end

        // shift in the new column; the second column of a row replicates the left edge
        win0_next = (s1_col_reg == CW'(1)) ? win2_reg : win1_reg;
        win1_next = win2_reg;
        left_b    = (s1_col_reg == '0) ? new_col : win1_next;

        has_a = active && (s1_col_reg != '0);
        has_b = active && s1_line_end_reg;

        row_x    = HCMP'(centre_row);
        in_range = (row_x >= HCMP'(first_row_reg)) && (row_x < HCMP'(end_row_reg))
                && (row_x < HCMP'(h_eff));
    end

    // the two possible results of this pixel
    sgm_pkg::result_t res_a;
    sgm_pkg::result_t res_b;
    logic [COLX-1:0]  col_a_x;
    logic [COLX-1:0]  col_b_x;
    logic [ROWX-1:0]  row_o_x;

    always_comb
    begin
        col_a_x = COLX'(s1_col_reg - CW'(1));
        col_b_x = COLX'(s1_col_reg);
        row_o_x = ROWX'(centre_row);

        res_a.col          = col_a_x[10:0];
        res_a.row          = row_o_x[11:0];
        res_a.write_enable = !win1_next.mid.alpha_zero && in_range;
        res_a.level        = sgm_pkg::is_flat(win0_next, win1_next, new_col)
                           ? sgm_pkg::LEVEL_FLAT : sgm_pkg::LEVEL_EDGE;
        res_a.last         = 1'b0;

        res_b.col          = col_b_x[10:0];
        res_b.row          = row_o_x[11:0];
        res_b.write_enable = !new_col.mid.alpha_zero && in_range;
        res_b.level        = sgm_pkg::is_flat(left_b, new_col, new_col)
                           ? sgm_pkg::LEVEL_FLAT : sgm_pkg::LEVEL_EDGE;
        res_b.last         = 1'b1;
    end

    // result sequencing: at most one result into the output register per cycle
    logic             pending;
    logic             cur_is_b;
    logic             out_free;
    logic             emit;
    logic             emit_final;
    sgm_pkg::result_t emit_data;
    logic             result_valid_reg;
    sgm_pkg::result_t result_reg;

    always_comb
    begin
        pending    = has_b || (has_a && !s1_sub_reg);
        cur_is_b   = !has_a || s1_sub_reg;
        out_free   = !result_valid_reg || !result_stall;
        emit       = s1_valid_reg && pending && out_free;
        emit_final = cur_is_b || !has_b;
        retire     = s1_valid_reg && (!pending || (emit && emit_final));
        emit_data  = cur_is_b ? res_b : res_a;
        emit_data.last = emit_final;
    end

    assign pixel_stall = s1_valid_reg && !retire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_sub_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (retire)
                s1_valid_reg <= 1'b0;

            if (retire)
                s1_sub_reg <= 1'b0;
            else if (emit)
                s1_sub_reg <= 1'b1;
        end
    end

    // window and flush state advance once per retired pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg          <= '0;
            win1_reg          <= '0;
            win2_reg          <= '0;
            flush_pending_reg <= 1'b0;
            flush_row_reg     <= '0;
        end
        else if (retire)
        begin
            win0_reg <= win0_next;
            win1_reg <= win1_next;
            win2_reg <= new_col;
            if (s1_frame_end_reg)
            begin
                flush_pending_reg <= 1'b1;
                flush_row_reg     <= s1_row_reg;
            end
            else if (first_row_of_frame && s1_line_end_reg)
            begin
                flush_pending_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            result_reg <= emit_data;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* hw/rtl/sgm_checker.sv */
// port-level checks for the sobel zero-gradient mask, bound to the top level
`default_nettype none

module sgm_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             pixel_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire sgm_pkg::result_t result
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // level is only ever flat or edge
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.level == sgm_pkg::LEVEL_FLAT
                          || result.level == sgm_pkg::LEVEL_EDGE))
        else $error("level outside its two codes");

    // input held back with an empty output means a result is on its way
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall && !result_valid |=> result_valid)
        else $error("input stalled with nothing to deliver");

endmodule

bind sobel_zero_gradient_mask sgm_checker u_sgm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for the streaming sobel zero-gradient mask
`timescale 1ns / 100ps

module tb;

    // geometry of the line stores, as built into the default instance
    localparam int unsigned MAX_W = 2048;
    localparam int unsigned MAX_H = 4096;

    // widest span of columns that any item reaches in the run after the store fill
    localparam int unsigned FILL_WIDTH = 32;

    // cycles allowed for the pipe to go quiet after the last result has come
    localparam int unsigned SETTLE_CYCLES = 8;
    // cycles with no handshake of any kind before the run is declared hung
    localparam int unsigned QUIET_LIMIT = 1000;
    // size of the random part, in items
    localparam int unsigned RANDOM_ITEMS = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // pixel side, driven by the test tasks
    logic pixel_valid = 1'b0;
    logic pixel_stall;
    sgm_pkg::pixel_t pixel = '0;

    // result side, stall driven by the back-pressure process below
    logic result_valid;
    logic result_stall = 1'b0;
    sgm_pkg::result_t result;

    // register write port
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = sgm_pkg::CFG_IMAGE_WIDTH;
    logic [sgm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // ------------------------------------------------------------------
    // mirror of the block: line stores, window, position and registers
    // ------------------------------------------------------------------
    sgm_pkg::line_entry_t older_line [MAX_W];
    sgm_pkg::line_entry_t prior_line [MAX_W];
    sgm_pkg::column_t win [3] = '{default: '0};
    int unsigned next_col = 0;
    int unsigned next_row = 0;
    bit flush_due = 1'b0;
    int unsigned flush_row_no = 0;

    int unsigned reg_width = sgm_pkg::RESET_IMAGE_WIDTH;
    int unsigned reg_height = sgm_pkg::RESET_IMAGE_HEIGHT;
    int unsigned reg_first = sgm_pkg::RESET_FIRST_ROW;
    int unsigned reg_end = sgm_pkg::RESET_END_ROW;

    // mask results still owed by the block, oldest first
    sgm_pkg::result_t mask_results_due [$];

    int unsigned mismatches = 0;

    // knobs of the stimulus: idle and stall odds in percent, and the tone
    // that most pixels of a frame share so that flat windows turn up
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned tone_pct = 0;
    sgm_pkg::pixel_t tone = '0;

    int unsigned hold_cycles = 0;
    int unsigned quiet_cycles = 0;

    sobel_zero_gradient_mask dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // 1-2-1 weighted sum across three gray values
    function automatic int taps(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        return int'(a) + 2 * int'(b) + int'(c);
    endfunction

    // one mask result for the centre column cc, with neighbours cl and cr
    function automatic sgm_pkg::result_t centre_result(input int unsigned col,
                                                       input int unsigned row,
                                                       input int unsigned h,
                                                       input sgm_pkg::column_t cl,
                                                       input sgm_pkg::column_t cc,
                                                       input sgm_pkg::column_t cr);
        int gx;
        int gy;
        sgm_pkg::result_t res;
        gx = taps(cr.top.gray, cr.mid.gray, cr.bot.gray)
           - taps(cl.top.gray, cl.mid.gray, cl.bot.gray);
        gy = taps(cl.bot.gray, cc.bot.gray, cr.bot.gray)
           - taps(cl.top.gray, cc.top.gray, cr.top.gray);
        res.col = 11'(col);
        res.row = 12'(row);
        // the write enable needs a visible centre and a row inside the window
        res.write_enable = !cc.mid.alpha_zero && row >= reg_first && row < reg_end
                           && row < h;
        res.level = (gx == 0 && gy == 0) ? sgm_pkg::LEVEL_FLAT : sgm_pkg::LEVEL_EDGE;
        res.last = 1'b0;
        return res;
    endfunction

    // move the mirror on by one accepted pixel and queue the results it owes
    task automatic advance_mask(input sgm_pkg::pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned crow;
        int unsigned gsum;
        int n;
        int k;
        bit row_done;
        bit frame_end;
        bit live;
        sgm_pkg::line_entry_t fresh;
        sgm_pkg::line_entry_t top;
        sgm_pkg::line_entry_t mid;
        sgm_pkg::line_entry_t bot;
        sgm_pkg::column_t fresh_col;
        sgm_pkg::column_t lft;
        sgm_pkg::result_t res [2];
        w = reg_width;
        h = reg_height;
        c = next_col;
        r = next_row;
        n = 0;
        // sizes out of range are pulled back into the stores' reach
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        if (h < 1) h = 1;
        if (h > MAX_H) h = MAX_H;
        // a count past a shrunken width ends the line there
        if (c >= w) c = w - 1;
        row_done = (c >= w - 1);
        frame_end = row_done && (r >= h - 1);

        gsum = 11 * px.red + 16 * px.green + 5 * px.blue;
        fresh.gray = 8'(gsum >> 5);
        fresh.alpha_zero = (px.alpha == 8'd0);

        mid = prior_line[c];
        if (r == 0)
        begin
            // first row of a frame: only the previous frame's last row can be
            // centred here, with its bottom neighbour replicated
            live = flush_due;
            crow = flush_row_no;
            top = (flush_row_no == 0) ? mid : older_line[c];
            bot = mid;
        end
        else
        begin
            live = 1'b1;
            crow = r - 1;
            top = (r == 1) ? mid : older_line[c];
            bot = fresh;
        end
        fresh_col.top = top;
        fresh_col.mid = mid;
        fresh_col.bot = bot;

        win[0] = win[1];
        win[1] = win[2];
        win[2] = fresh_col;
        // left border replicated on the first centre of a line
        if (c == 1) win[0] = win[1];

        if (live && c >= 1)
        begin
            res[n] = centre_result(c - 1, crow, h, win[0], win[1], win[2]);
            n++;
        end
        if (live && row_done)
        begin
            // right border replicated; a one-column line is its own left too
            lft = (c == 0) ? win[2] : win[1];
            res[n] = centre_result(c, crow, h, lft, win[2], win[2]);
            n++;
        end
        for (k = 0; k < n; k++)
        begin
            if (k == n - 1) res[k].last = 1'b1;
            mask_results_due.push_back(res[k]);
        end

        older_line[c] = mid;
        prior_line[c] = fresh;

        if (r == 0 && row_done) flush_due = 1'b0;
        if (row_done)
        begin
            next_col = 0;
            if (frame_end)
            begin
                flush_due = 1'b1;
                flush_row_no = r;
                next_row = 0;
            end
            else
            begin
                next_row = r + 1;
            end
        end
        else
        begin
            next_col = c + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // random pixel, mostly sharing the frame's tone; alpha zero now and then
    function automatic sgm_pkg::pixel_t pick_pixel();
        sgm_pkg::pixel_t px;
        px = sgm_pkg::pixel_t'($urandom);
        if ($urandom_range(0, 99) < tone_pct)
        begin
            px.red = tone.red;
            px.green = tone.green;
            px.blue = tone.blue;
        end
        if ($urandom_range(0, 5) == 0) px.alpha = 8'd0;
        return px;
    endfunction

    // idle odds for one stretch of the run, none in about a quarter of them
    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 25;
            default: return 60;
        endcase
    endfunction

    // offer one item, perhaps after an idle burst, and hold it until taken;
    // valid is left high so that a following item goes out back to back
    task automatic send_pixel(input sgm_pkg::pixel_t px);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= px;
        do @(posedge clk); while (pixel_stall);
        advance_mask(px);
    endtask

    task automatic send_pixels(input int unsigned count);
        repeat (count) send_pixel(pick_pixel());
    endtask

    // stop sending and let every owed result come out, then let the pipe
    // settle, since the last items may have owed nothing
    task automatic wait_drained();
        pixel_valid <= 1'b0;
        while (mask_results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the mirror takes it at the same edge as the block
    task automatic set_reg(input logic [1:0] idx,
                           input logic [sgm_pkg::CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            sgm_pkg::CFG_IMAGE_WIDTH: reg_width = value[11:0];
            sgm_pkg::CFG_IMAGE_HEIGHT: reg_height = value[12:0];
            sgm_pkg::CFG_FIRST_ROW: reg_first = value[12:0];
            sgm_pkg::CFG_END_ROW: reg_end = value[12:0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [12:0] width, input logic [12:0] height,
                             input logic [12:0] first, input logic [12:0] stop);
        wait_drained();
        set_reg(sgm_pkg::CFG_IMAGE_WIDTH, width);
        set_reg(sgm_pkg::CFG_IMAGE_HEIGHT, height);
        set_reg(sgm_pkg::CFG_FIRST_ROW, first);
        set_reg(sgm_pkg::CFG_END_ROW, stop);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // one frame of two rows spanning every column that later items reach fills
    // every entry of both line stores that the run reads, so no later size reads
    // an entry that was never written
    task automatic test_widest_rows();
        gap_pct = 10;
        stall_pct = 10;
        tone = sgm_pkg::pixel_t'($urandom);
        tone_pct = 90;
        configure(13'(FILL_WIDTH), 13'd2, 13'd0, 13'd4096);
        send_pixels(2 * FILL_WIDTH);
    endtask

    // border cases with hand-picked pixels and tiny frames
    task automatic test_directed_cases();
        gap_pct = 30;
        stall_pct = 30;
        tone = 32'h4060_20FF;
        tone_pct = 50;
        // zero sizes clamp to one pixel per frame; the first item flushes only
        // column 0 of the wide row left pending, the rest of it is dropped
        configure(13'd0, 13'd0, 13'd0, 13'd4096);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFF00_00FF);
        send_pixel(32'h00FF_0001);
        send_pixel(32'h0000_FF80);
        send_pixel(32'h8080_80FF);
        // single-row frames: top and bottom neighbours are the row itself
        configure(13'd3, 13'd1, 13'd0, 13'd4096);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h8080_80FF);
        send_pixel(32'hFFFF_FF01);
        // single-column rows: left and right neighbours are the centre
        configure(13'd1, 13'd3, 13'd0, 13'd4096);
        send_pixels(4);
        // two by two frames with a one-row write window
        configure(13'd2, 13'd2, 13'd1, 13'd2);
        send_pixels(5);
    endtask

    // write window limits, including empty windows and the row-below-height test
    task automatic test_row_window();
        logic [12:0] firsts [5];
        logic [12:0] stops [5];
        int i;
        firsts = '{13'd0, 13'd4096, 13'd2, 13'd1, 13'd0};
        stops = '{13'd0, 13'd4096, 13'd4, 13'h1FFF, 13'd3};
        gap_pct = 20;
        stall_pct = 20;
        tone = sgm_pkg::pixel_t'($urandom);
        tone_pct = 70;
        for (i = 0; i < 5; i++)
        begin
            configure(13'd4, 13'd5, firsts[i], stops[i]);
            send_pixels(20);
        end
        // the pending last row now lies beyond the new height
        configure(13'd4, 13'd2, 13'd0, 13'd4096);
        send_pixels(8);
    endtask

    // sizes changed part-way through lines and frames
    task automatic test_resize_midframe();
        gap_pct = 15;
        stall_pct = 15;
        tone = sgm_pkg::pixel_t'($urandom);
        tone_pct = 75;
        // oversized height clamps, so this frame does not end by itself
        configure(13'd6, 13'h1FFF, 13'd0, 13'd4096);
        send_pixels(18);
        wait_drained();
        // height shrunk below the current row: the next line end ends the frame
        set_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        send_pixels(3);
        wait_drained();
        // width shrunk behind the current column: the next item ends the line
        set_reg(sgm_pkg::CFG_IMAGE_WIDTH, 13'd2);
        send_pixels(1);
        wait_drained();
        set_reg(sgm_pkg::CFG_IMAGE_HEIGHT, 13'd3);
        send_pixels(2);
        wait_drained();
        // width grown in mid-frame
        set_reg(sgm_pkg::CFG_IMAGE_WIDTH, 13'd5);
        send_pixels(10);
        wait_drained();
        // oversized width clamps to the store depth, then shrinks mid-line
        set_reg(sgm_pkg::CFG_IMAGE_WIDTH, 13'h1FFF);
        send_pixels(4);
        wait_drained();
        set_reg(sgm_pkg::CFG_IMAGE_WIDTH, 13'd3);
        send_pixels(4);
    endtask

    // random frames of random size, mostly whole, some cut short
    task automatic test_random_frames();
        int unsigned made;
        int unsigned w;
        int unsigned h;
        int unsigned span;
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = 1;
                2: w = 2;
                8: w = $urandom_range(13, FILL_WIDTH);
                default: w = $urandom_range(3, 12);
            endcase
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            gap_pct = pick_pct();
            stall_pct = pick_pct();
            tone = sgm_pkg::pixel_t'($urandom);
            tone_pct = $urandom_range(0, 100);
            configure(13'(w), 13'(h), 13'($urandom_range(0, 4)),
                      ($urandom_range(0, 2) == 0) ? 13'($urandom_range(0, 7)) : 13'd4096);
            span = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * $urandom_range(1, 2);
            // a broken frame leaves the next setting to land mid-frame
            if ($urandom_range(0, 7) == 0) span = $urandom_range(1, span);
            if (span > RANDOM_ITEMS - made) span = RANDOM_ITEMS - made;
            send_pixels(span);
            made += span;
        end
    endtask

    // closing stretch at full rate with no idling on either side
    task automatic test_steady_stream();
        gap_pct = 0;
        stall_pct = 0;
        tone = sgm_pkg::pixel_t'($urandom);
        tone_pct = 60;
        configure(13'd7, 13'd4, 13'd1, 13'd3);
        send_pixels(56);
        configure(13'd1, 13'd5, 13'd0, 13'd4096);
        send_pixels(10);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // random stall bursts
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
            hold_cycles--;
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            hold_cycles = $urandom_range(1, 16);
        result_stall <= (hold_cycles != 0);
    end

    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // every accepted result against the oldest one owed
    always @(posedge clk)
    begin
        sgm_pkg::result_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (mask_results_due.size() == 0)
            begin
                $error("result with none owed: col %0d row %0d", result.col, result.row);
                mismatches++;
            end
            else
            begin
                want = mask_results_due.pop_front();
                compare_field("col", 12'(want.col), 12'(result.col));
                compare_field("row", want.row, result.row);
                compare_field("write_enable", 12'(want.write_enable),
                              12'(result.write_enable));
                compare_field("level", 12'(want.level), 12'(result.level));
                compare_field("last", 12'(want.last), 12'(result.last));
            end
        end
    end

    // hang detector: too long without any item, result or register write
    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_widest_rows();
        test_directed_cases();
        test_row_window();
        test_resize_midframe();
        test_random_frames();
        test_steady_stream();
        wait_drained();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sgm_pkg.sv
hw/rtl/sgm_line_buf.sv
hw/rtl/sobel_zero_gradient_mask.sv
hw/rtl/sgm_checker.sv
dv/tb.sv
